>>> rtl/core/running_median_odd_prefix_top_assert.svh
// Assertion macros for the running median block.
// Expects clk and arst_n in the scope of use.
`ifndef RUNNING_MEDIAN_ODD_PREFIX_TOP_ASSERT_SVH
`define RUNNING_MEDIAN_ODD_PREFIX_TOP_ASSERT_SVH

// Same-cycle implication.
`define RMOP_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("running median: check failed");

// Next-cycle implication.
`define RMOP_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("running median: check failed");

`endif

>>> rtl/core/rmop_pkg.sv
// Package for the running median block: beat types, cell control, states.
// No dependencies.
package rmop_pkg;

	localparam int MAX_SAMPLES_DEF = 64;
	localparam int GROUP_SIZE      = 8;
	localparam int SAMPLE_W        = 32;
	localparam int LEN_W           = 7;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] sample;
		logic                       first;
	} req_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] median;
		logic [LEN_W-1:0]           prefix_length;
		logic                       overflow;
	} rsp_t;

	typedef struct packed {
		logic ins;
		logic clr;
	} cell_ctrl_t;

	typedef enum logic [2:0] {
		S_IDLE  = 3'b001,
		S_GROUP = 3'b010,
		S_FINAL = 3'b100
	} state_t;

endpackage

>>> rtl/core/rmop_cell.sv
// One slot of the sorted insertion chain: holds one sample, shifts on insert.
// Depends on rmop_pkg.
module rmop_cell import rmop_pkg::*; #(
	parameter int CNT_W = 7,
	parameter int IDX   = 0
) (
	input  logic                       clk,
	input  cell_ctrl_t                 ctrl,
	input  logic signed [SAMPLE_W-1:0] key,
	input  logic [CNT_W-1:0]           count,
	input  logic [CNT_W-1:0]           med_idx,
	input  logic signed [SAMPLE_W-1:0] prev_val,
	input  logic                       prev_gt,
	output logic signed [SAMPLE_W-1:0] val,
	output logic                       gt,
	output logic [SAMPLE_W-1:0]        tap
);

	localparam logic [CNT_W-1:0] MY_IDX = CNT_W'(IDX);

	logic signed [SAMPLE_W-1:0] val_q;

	assign val = val_q;
	assign gt  = ctrl.clr || (MY_IDX >= count) || (val_q > key);
	assign tap = (med_idx == MY_IDX) ? val_q : '0;

	always_ff @(posedge clk) begin
		if (ctrl.ins) begin
			if (prev_gt) begin
				val_q <= prev_val;
			end else if (gt) begin
				val_q <= key;
			end
		end
	end

endmodule

>>> rtl/core/running_median_odd_prefix_top.sv
// Running median of odd-length prefixes: top level with control and readout.
// Depends on rmop_pkg, rmop_cell and running_median_odd_prefix_top_assert.svh.
//
// Use: samples enter on req (req_valid/req_ready), one beat per sample, with
// req.first set on the first sample of a sequence. The block keeps the sequence
// sorted in a chain of MAX_SAMPLES cells; a sample is placed as it is taken.
// After every odd-numbered sample a beat leaves on rsp (rsp_valid/rsp_ready)
// carrying the median and the prefix length. Even-numbered samples give no beat.
// When the chain is full the sample is dropped and a beat repeats the last
// median and length with overflow set, until a sample with first arrives.
// Readout: a median passes the group registers in S_GROUP and then the output
// register in S_FINAL; a drop beat goes from S_FINAL into the output register.
// Throughput: one sample per cycle while even-numbered samples arrive and the
// chain is not full; an item with a median holds req_ready low through S_GROUP
// and S_FINAL, set by the two-level registered OR tree that reads the median
// cell out of the chain; a dropped item holds it low through S_FINAL only.
// Reset clears the count, the last result and the output valid flag; the cells
// themselves hold nothing meaningful until written. When rsp stalls, the
// finished result waits in the output register; a further result waits in the
// readout stage and req_ready stays low until it moves on.
module running_median_odd_prefix_top import rmop_pkg::*; #(
	parameter int MAX_SAMPLES = MAX_SAMPLES_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_ready,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_ready,
	output rsp_t rsp
);

	localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
	localparam int NGRP  = (MAX_SAMPLES + GROUP_SIZE - 1) / GROUP_SIZE;
	localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_SAMPLES);

	state_t                     state_q;
	logic [CNT_W-1:0]           cnt_q;
	logic [CNT_W-1:0]           med_idx_q;
	logic                       ovf_q;
	logic signed [SAMPLE_W-1:0] last_med_q;
	logic [LEN_W-1:0]           last_len_q;
	logic                       rsp_valid_q;
	rsp_t                       rsp_q;
	logic [SAMPLE_W-1:0]        grp_q [NGRP];

	cell_ctrl_t                 ctrl;
	logic                       take;
	logic [CNT_W-1:0]           cnt_eff;
	logic                       full;
	logic [CNT_W-1:0]           cnt_next;
	logic signed [SAMPLE_W-1:0] cval [MAX_SAMPLES];
	logic                       cgt  [MAX_SAMPLES];
	logic [SAMPLE_W-1:0]        taps [NGRP*GROUP_SIZE];
	logic [SAMPLE_W-1:0]        grp_or [NGRP];
	logic [SAMPLE_W-1:0]        med_or;
	logic                       load;
	logic [CNT_W+LEN_W-1:0]     cnt_ext;

	assign req_ready = (state_q == S_IDLE);
	assign take      = req_valid && req_ready;
	assign cnt_eff   = req.first ? '0 : cnt_q;
	assign full      = (cnt_eff >= MAX_CNT);
	assign cnt_next  = cnt_eff + CNT_W'(1);
	assign ctrl.ins  = take && !full;
	assign ctrl.clr  = req.first;
	assign cnt_ext   = {{LEN_W{1'b0}}, cnt_q};

	for (genvar i = 0; i < NGRP * GROUP_SIZE; i++) begin : g_cell
		if (i < MAX_SAMPLES) begin : g_live
			rmop_cell #(
				.CNT_W (CNT_W),
				.IDX   (i)
			) u_cell (
				.clk      (clk),
				.ctrl     (ctrl),
				.key      (req.sample),
				.count    (cnt_q),
				.med_idx  (med_idx_q),
				.prev_val ((i == 0) ? req.sample : cval[(i == 0) ? 0 : i-1]),
				.prev_gt  ((i == 0) ? 1'b0 : cgt[(i == 0) ? 0 : i-1]),
				.val      (cval[i]),
				.gt       (cgt[i]),
				.tap      (taps[i])
			);
		end else begin : g_pad
			assign taps[i] = '0;
		end
	end

	always_comb begin
		for (int g = 0; g < NGRP; g++) begin
			grp_or[g] = '0;
			for (int j = 0; j < GROUP_SIZE; j++) begin
				grp_or[g] = grp_or[g] | taps[g*GROUP_SIZE + j];
			end
		end
	end

	always_comb begin
		med_or = '0;
		for (int g = 0; g < NGRP; g++) begin
			med_or = med_or | grp_q[g];
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_GROUP) begin
			grp_q <= grp_or;
		end
	end

	assign load = (state_q == S_FINAL) && (!rsp_valid_q || rsp_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			med_idx_q   <= '0;
			ovf_q       <= 1'b0;
			last_med_q  <= '0;
			last_len_q  <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (take) begin
						if (full) begin
							ovf_q   <= 1'b1;
							cnt_q   <= cnt_eff;
							state_q <= S_FINAL;
						end else begin
							ovf_q <= 1'b0;
							cnt_q <= cnt_next;
							if (cnt_next[0]) begin
								med_idx_q <= cnt_eff >> 1;
								state_q   <= S_GROUP;
							end
						end
					end
				end
				S_GROUP: begin
					state_q <= S_FINAL;
				end
				S_FINAL: begin
					if (load) begin
						if (!ovf_q) begin
							last_med_q <= $signed(med_or);
							last_len_q <= cnt_ext[LEN_W-1:0];
						end
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
			if (load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			if (ovf_q) begin
				rsp_q.median        <= last_med_q;
				rsp_q.prefix_length <= last_len_q;
				rsp_q.overflow      <= 1'b1;
			end else begin
				rsp_q.median        <= $signed(med_or);
				rsp_q.prefix_length <= cnt_ext[LEN_W-1:0];
				rsp_q.overflow      <= 1'b0;
			end
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

`include "running_median_odd_prefix_top_assert.svh"

	`RMOP_ASSERT_NOW(a_cnt_bound, 1'b1, cnt_q <= MAX_CNT)
	`RMOP_ASSERT_NEXT(a_group_to_final, state_q == S_GROUP, state_q == S_FINAL)
	`RMOP_ASSERT_NOW(a_odd_prefix, state_q == S_GROUP, cnt_q[0] && !ovf_q)

endmodule
